// ===== rtl/core/sphc_pkg.sv =====
package sphc_pkg;

   typedef enum logic [2:0] {
      ACT_STEP_DONE = 3'd0,
      ACT_LIMIT_HIT = 3'd1,
      ACT_START_HOME = 3'd2,
      ACT_RAW_MOVE = 3'd3,
      ACT_LIMITED_MOVE = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_SUCCESS = 2'd0,
      ST_NOT_YET = 2'd1,
      ST_CLAMPED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      HOME_NONE = 2'd0,
      HOME_SEEKING = 2'd1,
      HOME_AT_SWITCH = 2'd2,
      HOME_DONE = 2'd3
   } home_type;

   typedef enum logic [2:0] {
      CSR_DEG_PER_COUNT = 3'd0,
      CSR_COUNTS_PER_DEG = 3'd1,
      CSR_BIAS_COUNTS = 3'd2,
      CSR_ANGLE_LIMIT = 3'd3,
      CSR_HOME_DIR_UP = 3'd4
   } csr_index_type;

   localparam logic [15:0] DEG_PER_COUNT_RESET = 16'd7373;
   localparam logic [19:0] COUNTS_PER_DEG_RESET = 20'd36409;
   localparam logic [11:0] BIAS_COUNTS_RESET = 12'hFE6;
   localparam logic [6:0] ANGLE_LIMIT_RESET = 7'd80;
   localparam logic HOME_DIR_UP_RESET = 1'b1;

endpackage

// ===== rtl/core/stepper_position_homing_control_top.sv =====
// Position and homing control for one stepper axis.
// Requests arrive on req_valid/req_ready with an action code and a signed
// relative move in whole degrees. Each request yields exactly one response on
// rsp_valid/rsp_ready carrying a status and the axis state after the event:
// running, direction, homing state, step count and the Q8.8 angle.
// Configuration registers are written through csr_we, csr_index and csr_wdata.
// Write them only while no request is in flight; this is not enforced.
// A request is captured in an input register and processed once the response
// register can take it, where the state registers and the response register
// update together. One request is taken every cycle while the receiver does
// not stall. The state update of one request feeds the next through the
// multiply, round and saturate paths, which set the clock period.
// When the receiver stalls, the response holds and one more request can wait
// in the input register; req_ready drops only when both are full.
// Synchronous reset clears the axis state to not homed, count zero, direction
// up and stopped, and restores the configuration registers to their defaults.
module stepper_position_homing_control_top #(
   parameter int COUNT_WIDTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [2:0]         req_action,
   input  logic signed [8:0]  req_angle_delta,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_status,
   output logic               rsp_running,
   output logic               rsp_dir_up,
   output logic [1:0]         rsp_home_state,
   output logic signed [15:0] rsp_position_count,
   output logic signed [15:0] rsp_angle_q8,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [19:0]        csr_wdata
);

   localparam int CW = COUNT_WIDTH;
   localparam int PRW = CW + 18;
   localparam int AW = PRW - 8;
   localparam int TW = ((CW > 20) ? CW : 20) + 1;
   localparam int PW = (CW > 16) ? CW : 16;
   localparam logic signed [AW-1:0] ANG_MAX = AW'(32767);
   localparam logic signed [AW-1:0] ANG_MIN = AW'(-32768);
   localparam logic signed [TW-1:0] T_MAX = TW'((64'sd1 <<< (CW - 1)) - 64'sd1);
   localparam logic signed [TW-1:0] T_MIN = TW'(-(64'sd1 <<< (CW - 1)));

   logic [15:0] dpc_ff;
   logic [19:0] cpd_ff;
   logic [11:0] bias_ff;
   logic [6:0] limit_ff;
   logic home_dir_ff;

   logic s1_valid_ff, s1_valid_in;
   logic [2:0] s1_action_ff;
   logic signed [8:0] s1_delta_ff;

   logic [CW-1:0] step_ff, step_in;
   logic [CW-1:0] target_ff, target_in;
   logic up_ff, up_in;
   logic run_ff, run_in;
   sphc_pkg::home_type phase_ff, phase_in;
   logic signed [15:0] angle_ff, angle_in;

   logic rsp_valid_ff;
   sphc_pkg::status_type status_ff, status_in;
   logic [15:0] pos_out_ff;
   logic [PW-1:0] pos_wide;

   logic advance, accept, fire;
   sphc_pkg::action_type action;

   logic [CW-1:0] stepped;
   logic signed [CW:0] sum;
   logic signed [16:0] dpc_s;
   logic signed [PRW-1:0] prod, prod_rnd;
   logic signed [AW-1:0] ang_sh;
   logic signed [15:0] ang_sat;

   logic signed [17:0] a_raw, a_lim, a_sel, lim_pos, lim_neg;
   logic clamped;
   logic signed [20:0] cpd_s;
   logic signed [38:0] mprod, mprod_rnd;
   logic signed [18:0] t0;
   logic signed [TW-1:0] t1, t_sat, cur;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;
   assign accept = req_valid && req_ready;
   assign fire = s1_valid_ff && advance;
   assign action = sphc_pkg::action_type'(s1_action_ff);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // Angle from the step count.
   always_comb begin
      stepped = up_ff ? (step_ff + CW'(1)) : (step_ff - CW'(1));
      if (action == sphc_pkg::ACT_STEP_DONE) begin
         sum = (CW + 1)'($signed(stepped)) + (CW + 1)'($signed(bias_ff));
      end else begin
         sum = (CW + 1)'($signed(step_ff)) + (CW + 1)'($signed(bias_ff));
      end
      dpc_s = $signed({1'b0, dpc_ff});
      prod = dpc_s * sum;
      prod_rnd = prod + PRW'(128);
      ang_sh = AW'(prod_rnd >>> 8);
      if (ang_sh > ANG_MAX) begin
         ang_sat = 16'sh7FFF;
      end else if (ang_sh < ANG_MIN) begin
         ang_sat = -16'sh8000;
      end else begin
         ang_sat = ang_sh[15:0];
      end
   end

   // Target count from a target angle.
   always_comb begin
      a_raw = 18'(angle_ff) + 18'($signed({s1_delta_ff, 8'd0}));
      lim_pos = $signed({3'd0, limit_ff, 8'd0});
      lim_neg = -lim_pos;
      clamped = 1'b1;
      if (a_raw < lim_neg) begin
         a_lim = lim_neg;
      end else if (a_raw > lim_pos) begin
         a_lim = lim_pos;
      end else begin
         a_lim = a_raw;
         clamped = 1'b0;
      end
      a_sel = (action == sphc_pkg::ACT_LIMITED_MOVE) ? a_lim : a_raw;
      cpd_s = $signed({1'b0, cpd_ff});
      mprod = a_sel * cpd_s;
      mprod_rnd = mprod + 39'sd524288;
      t0 = mprod_rnd[38:20];
      t1 = TW'(t0) - TW'($signed(bias_ff));
      if (t1 > T_MAX) begin
         t_sat = T_MAX;
      end else if (t1 < T_MIN) begin
         t_sat = T_MIN;
      end else begin
         t_sat = t1;
      end
      cur = TW'($signed(step_ff));
   end

   always_comb begin
      step_in = step_ff;
      target_in = target_ff;
      up_in = up_ff;
      run_in = run_ff;
      phase_in = phase_ff;
      angle_in = angle_ff;
      status_in = sphc_pkg::ST_SUCCESS;
      if (fire) begin
         unique case (action)
            sphc_pkg::ACT_STEP_DONE: begin
               if (phase_ff == sphc_pkg::HOME_AT_SWITCH || phase_ff == sphc_pkg::HOME_DONE) begin
                  step_in = stepped;
                  angle_in = ang_sat;
                  if (stepped == target_ff && run_ff) begin
                     run_in = 1'b0;
                     if (phase_ff == sphc_pkg::HOME_AT_SWITCH) begin
                        phase_in = sphc_pkg::HOME_DONE;
                     end
                  end
               end
            end
            sphc_pkg::ACT_LIMIT_HIT: begin
               if (phase_ff == sphc_pkg::HOME_SEEKING) begin
                  run_in = 1'b0;
                  phase_in = sphc_pkg::HOME_AT_SWITCH;
                  angle_in = ang_sat;
               end
            end
            sphc_pkg::ACT_START_HOME: begin
               if (phase_ff == sphc_pkg::HOME_NONE) begin
                  up_in = home_dir_ff;
                  run_in = 1'b1;
                  phase_in = sphc_pkg::HOME_SEEKING;
               end
            end
            sphc_pkg::ACT_RAW_MOVE, sphc_pkg::ACT_LIMITED_MOVE: begin
               if ((action == sphc_pkg::ACT_RAW_MOVE &&
                    (phase_ff == sphc_pkg::HOME_NONE || phase_ff == sphc_pkg::HOME_SEEKING)) ||
                   (action == sphc_pkg::ACT_LIMITED_MOVE && phase_ff != sphc_pkg::HOME_DONE)) begin
                  status_in = sphc_pkg::ST_NOT_YET;
               end else if (s1_delta_ff != 9'sd0) begin
                  if (action == sphc_pkg::ACT_LIMITED_MOVE && clamped) begin
                     status_in = sphc_pkg::ST_CLAMPED;
                  end
                  target_in = t_sat[CW-1:0];
                  up_in = (t_sat >= cur);
                  if (t_sat == cur) begin
                     run_in = 1'b0;
                     if (phase_ff == sphc_pkg::HOME_AT_SWITCH) begin
                        phase_in = sphc_pkg::HOME_DONE;
                     end
                  end else begin
                     run_in = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign pos_wide = PW'(step_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         dpc_ff <= sphc_pkg::DEG_PER_COUNT_RESET;
         cpd_ff <= sphc_pkg::COUNTS_PER_DEG_RESET;
         bias_ff <= sphc_pkg::BIAS_COUNTS_RESET;
         limit_ff <= sphc_pkg::ANGLE_LIMIT_RESET;
         home_dir_ff <= sphc_pkg::HOME_DIR_UP_RESET;
      end else if (csr_we) begin
         unique case (sphc_pkg::csr_index_type'(csr_index))
            sphc_pkg::CSR_DEG_PER_COUNT: dpc_ff <= csr_wdata[15:0];
            sphc_pkg::CSR_COUNTS_PER_DEG: cpd_ff <= csr_wdata;
            sphc_pkg::CSR_BIAS_COUNTS: bias_ff <= csr_wdata[11:0];
            sphc_pkg::CSR_ANGLE_LIMIT: limit_ff <= csr_wdata[6:0];
            sphc_pkg::CSR_HOME_DIR_UP: home_dir_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         step_ff <= '0;
         target_ff <= '0;
         up_ff <= 1'b1;
         run_ff <= 1'b0;
         phase_ff <= sphc_pkg::HOME_NONE;
         angle_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (advance) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         step_ff <= step_in;
         target_ff <= target_in;
         up_ff <= up_in;
         run_ff <= run_in;
         phase_ff <= phase_in;
         angle_ff <= angle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_action_ff <= req_action;
         s1_delta_ff <= req_angle_delta;
      end
      if (fire) begin
         status_ff <= status_in;
         pos_out_ff <= pos_wide[15:0];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = status_ff;
   assign rsp_running = run_ff;
   assign rsp_dir_up = up_ff;
   assign rsp_home_state = phase_ff;
   assign rsp_position_count = $signed(pos_out_ff);
   assign rsp_angle_q8 = angle_ff;

endmodule
